/* rtl/lfc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lfc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAGIC_FIRST      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAGIC_SECOND     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORMAT_VERSION   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_FRAME_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRC_SEED         = 3'd4;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd1;
   localparam logic [2:0] STATUS_HEADER    = 3'd2;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd3;
   localparam logic [2:0] STATUS_CRC       = 3'd4;

   localparam logic [8:0]  HDR_BYTES  = 9'd5;
   localparam logic [8:0]  CRC_BYTES  = 9'd2;
   localparam logic [8:0]  MIN_FRAME  = 9'd7;
   localparam logic [8:0]  COUNT_CAP  = 9'd263;
   localparam logic [15:0] CRC_POLY   = 16'h1021;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       frame_ok;
      logic [7:0] frame_type;
      logic [8:0] frame_length;
      logic [2:0] check_status;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  magic_first;
      logic [7:0]  magic_second;
      logic [7:0]  format_version;
      logic [8:0]  max_frame_length;
      logic [15:0] crc_seed;
   } cfg_type;

   // Bytewise CRC16-CCITT update, MSB first, no reflection.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/log_frame_checker_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Log frame checker. Feed the buffer one byte per request, byte zero first,
// and set last_byte on the final byte. The block parses the frame at the
// head of the buffer (two magic bytes, version, type, payload length,
// payload, CRC16-CCITT low byte first) and returns one response per buffer,
// from the response register in the cycle after the request carrying
// last_byte is taken. The header compare and the bytewise CRC update are
// combinational between the frame state registers and the response
// register, so a new byte is taken every cycle while rsp_ready is high or
// the response register is empty. A response that waits on rsp_ready holds
// req_ready low until it is taken, so the byte stream pauses behind it.
// Program the CSRs only while idle; csr_ready is always high and writes to
// unknown indexes are dropped.
module log_frame_checker_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire lfc_pkg::req_type                    req_payload,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output lfc_pkg::rsp_type                         rsp_payload,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [lfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [15:0]                         csr_data
);

   lfc_pkg::cfg_type cfg;
   lfc_pkg::rsp_type result;
   lfc_pkg::rsp_type rsp_payload_ff;
   logic             rsp_valid_ff;
   logic             req_accept;

   // Take a request unless a finished response is stuck in the output register.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   lfc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lfc_frame_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_payload),
      .cfg    (cfg),
      .result (result)
   );

   // Load a response on the last byte; otherwise drop valid once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_payload.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_payload.last_byte) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.last_byte |=> rsp_valid)
      else $error("last byte did not produce a response");

   a_mid_no_new_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready && req_payload.last_byte) |=> !rsp_valid)
      else $error("response appeared without a last byte");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.frame_ok == (rsp_payload.check_status == lfc_pkg::STATUS_OK)))
      else $error("frame_ok disagrees with status");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.frame_ok |->
         rsp_payload.frame_length == 9'd0 && rsp_payload.frame_type == 8'd0)
      else $error("invalid frame reports length or type");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_ok |-> rsp_payload.frame_length >= lfc_pkg::MIN_FRAME)
      else $error("valid frame shorter than minimum");

endmodule

`default_nettype wire

/* rtl/lfc_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module lfc_cfg_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [lfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [15:0]                         csr_data,
   output lfc_pkg::cfg_type                         cfg
);

   lfc_pkg::cfg_type cfg_ff;
   lfc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            lfc_pkg::CSR_MAGIC_FIRST:      cfg_in.magic_first      = csr_data[7:0];
            lfc_pkg::CSR_MAGIC_SECOND:     cfg_in.magic_second     = csr_data[7:0];
            lfc_pkg::CSR_FORMAT_VERSION:   cfg_in.format_version   = csr_data[7:0];
            lfc_pkg::CSR_MAX_FRAME_LENGTH: cfg_in.max_frame_length = csr_data[8:0];
            lfc_pkg::CSR_CRC_SEED:         cfg_in.crc_seed         = csr_data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first      <= 8'd0;
         cfg_ff.magic_second     <= 8'd0;
         cfg_ff.format_version   <= 8'd1;
         cfg_ff.max_frame_length <= 9'd64;
         cfg_ff.crc_seed         <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/lfc_frame_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module lfc_frame_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire lfc_pkg::req_type req,
   input  wire lfc_pkg::cfg_type cfg,
   output lfc_pkg::rsp_type      result
);

   logic [8:0]  byte_count_ff, byte_count_in;
   logic        header_mismatch_ff, header_mismatch_in;
   logic [7:0]  record_type_ff, record_type_in;
   logic [7:0]  payload_size_ff, payload_size_in;
   logic [15:0] crc_running_ff, crc_running_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic        crc_matched_ff, crc_matched_in;
   logic        frame_done_ff, frame_done_in;

   logic [8:0]  crc_pos;
   logic [8:0]  total;
   logic [2:0]  status;

   assign crc_pos = {1'b0, payload_size_ff} + lfc_pkg::HDR_BYTES;

   always_comb begin
      byte_count_in      = byte_count_ff;
      header_mismatch_in = header_mismatch_ff;
      record_type_in     = record_type_ff;
      payload_size_in    = payload_size_ff;
      crc_running_in     = crc_running_ff;
      crc_low_in         = crc_low_ff;
      crc_matched_in     = crc_matched_ff;
      frame_done_in      = frame_done_ff;

      if (!frame_done_ff) begin
         if (byte_count_ff == 9'd0) begin
            if (req.data_byte != cfg.magic_first) header_mismatch_in = 1'b1;
         end else if (byte_count_ff == 9'd1) begin
            if (req.data_byte != cfg.magic_second) header_mismatch_in = 1'b1;
         end else if (byte_count_ff == 9'd2) begin
            if (req.data_byte != cfg.format_version) header_mismatch_in = 1'b1;
            crc_running_in = lfc_pkg::crc_byte(cfg.crc_seed, req.data_byte);
         end else if (byte_count_ff == 9'd3) begin
            record_type_in = req.data_byte;
            crc_running_in = lfc_pkg::crc_byte(crc_running_ff, req.data_byte);
         end else if (byte_count_ff == 9'd4) begin
            payload_size_in = req.data_byte;
            crc_running_in  = lfc_pkg::crc_byte(crc_running_ff, req.data_byte);
         end else if (byte_count_ff < crc_pos) begin
            crc_running_in = lfc_pkg::crc_byte(crc_running_ff, req.data_byte);
         end else if (byte_count_ff == crc_pos) begin
            crc_low_in = req.data_byte;
         end else begin
            crc_matched_in = ({req.data_byte, crc_low_ff} == crc_running_ff);
            frame_done_in  = 1'b1;
         end
      end
      if (byte_count_ff < lfc_pkg::COUNT_CAP) byte_count_in = byte_count_ff + 9'd1;

      total = {1'b0, payload_size_in} + lfc_pkg::HDR_BYTES + lfc_pkg::CRC_BYTES;
      if (byte_count_in < lfc_pkg::MIN_FRAME)    status = lfc_pkg::STATUS_TRUNCATED;
      else if (header_mismatch_in)               status = lfc_pkg::STATUS_HEADER;
      else if (total > cfg.max_frame_length)     status = lfc_pkg::STATUS_TOO_LONG;
      else if (!frame_done_in)                   status = lfc_pkg::STATUS_TRUNCATED;
      else if (!crc_matched_in)                  status = lfc_pkg::STATUS_CRC;
      else                                       status = lfc_pkg::STATUS_OK;

      result.check_status = status;
      result.frame_ok     = (status == lfc_pkg::STATUS_OK);
      result.frame_type   = result.frame_ok ? record_type_in : 8'd0;
      result.frame_length = result.frame_ok ? total : 9'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req.last_byte)) begin
         byte_count_ff      <= 9'd0;
         header_mismatch_ff <= 1'b0;
         record_type_ff     <= 8'd0;
         payload_size_ff    <= 8'd0;
         crc_running_ff     <= cfg.crc_seed;
         crc_low_ff         <= 8'd0;
         crc_matched_ff     <= 1'b0;
         frame_done_ff      <= 1'b0;
      end else if (accept) begin
         byte_count_ff      <= byte_count_in;
         header_mismatch_ff <= header_mismatch_in;
         record_type_ff     <= record_type_in;
         payload_size_ff    <= payload_size_in;
         crc_running_ff     <= crc_running_in;
         crc_low_ff         <= crc_low_in;
         crc_matched_ff     <= crc_matched_in;
         frame_done_ff      <= frame_done_in;
      end
   end

endmodule

`default_nettype wire

/* dv/tb_log_frame_checker_core.sv */
`timescale 1ns / 1ps

module tb_log_frame_checker_core;

   localparam int unsigned CYCLE_LIMIT = 200000;
   // first register index that the block does not decode
   localparam logic [lfc_pkg::CSR_INDEX_WIDTH-1:0] CSR_FIRST_UNUSED =
      lfc_pkg::CSR_CRC_SEED + 3'd1;

   typedef enum logic [2:0] {
      BUF_GOOD,
      BUF_BAD_CRC,
      BUF_BAD_HEADER,
      BUF_CUT_SHORT,
      BUF_OVERSIZE,
      BUF_NOISE
   } buffer_kind_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   lfc_pkg::req_type                    req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   lfc_pkg::rsp_type                    rsp_payload;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [lfc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [15:0]                         csr_data = '0;

   // requests waiting for the driver, and responses the frame parser must return
   lfc_pkg::req_type byte_queue[$];
   lfc_pkg::rsp_type expected_results[$];
   lfc_pkg::rsp_type want;

   // register copy, updated as each CSR write is taken
   lfc_pkg::cfg_type cfg_shadow = '{magic_first: 8'h00, magic_second: 8'h00,
                                    format_version: 8'h01, max_frame_length: 9'd64,
                                    crc_seed: 16'hFFFF};

   // frame parse state of the predictor
   int unsigned scan_count = 0;
   logic        hdr_bad = 1'b0;
   logic [7:0]  rec_type = '0;
   logic [7:0]  pay_len = '0;
   logic [15:0] crc_acc = '0;
   logic [7:0]  crc_lo_seen = '0;
   logic        crc_good = 1'b0;
   logic        frame_closed = 1'b0;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned total_queued = 0;
   int unsigned bytes_taken = 0;
   int unsigned buffers_queued = 0;
   int unsigned results_checked = 0;
   int unsigned settings_applied = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   log_frame_checker_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // CRC16-CCITT, one data bit at a time, MSB first
   function automatic logic [15:0] crc_ccitt_next(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = acc;
      for (int n = 7; n >= 0; n--) begin
         fb = c[15] ^ d[n];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ lfc_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   // Advance the frame parser by one request; on the last byte of a buffer,
   // queue the response and clear the parse state.
   function automatic void advance_frame_state(input lfc_pkg::req_type r);
      int unsigned      pos;
      int unsigned      total;
      logic [2:0]       status;
      lfc_pkg::rsp_type res;
      pos = scan_count;
      if (!frame_closed) begin
         if (pos == 0) begin
            if (r.data_byte != cfg_shadow.magic_first) hdr_bad = 1'b1;
         end else if (pos == 1) begin
            if (r.data_byte != cfg_shadow.magic_second) hdr_bad = 1'b1;
         end else if (pos == 2) begin
            if (r.data_byte != cfg_shadow.format_version) hdr_bad = 1'b1;
            // seed is taken from the register as it stands at the version byte
            crc_acc = crc_ccitt_next(cfg_shadow.crc_seed, r.data_byte);
         end else if (pos == 3) begin
            rec_type = r.data_byte;
            crc_acc  = crc_ccitt_next(crc_acc, r.data_byte);
         end else if (pos == 4) begin
            pay_len = r.data_byte;
            crc_acc = crc_ccitt_next(crc_acc, r.data_byte);
         end else if (pos < lfc_pkg::HDR_BYTES + pay_len) begin
            crc_acc = crc_ccitt_next(crc_acc, r.data_byte);
         end else if (pos == lfc_pkg::HDR_BYTES + pay_len) begin
            crc_lo_seen = r.data_byte;
         end else begin
            crc_good     = ({r.data_byte, crc_lo_seen} == crc_acc);
            frame_closed = 1'b1;
         end
      end
      // count saturates; bytes past the frame only advance it
      if (scan_count < lfc_pkg::COUNT_CAP) scan_count++;
      if (!r.last_byte) return;

      total = lfc_pkg::HDR_BYTES + pay_len + lfc_pkg::CRC_BYTES;
      if (scan_count < lfc_pkg::MIN_FRAME) status = lfc_pkg::STATUS_TRUNCATED;
      else if (hdr_bad) status = lfc_pkg::STATUS_HEADER;
      else if (total > cfg_shadow.max_frame_length) status = lfc_pkg::STATUS_TOO_LONG;
      else if (!frame_closed) status = lfc_pkg::STATUS_TRUNCATED;
      else if (!crc_good) status = lfc_pkg::STATUS_CRC;
      else status = lfc_pkg::STATUS_OK;

      res.frame_ok     = (status == lfc_pkg::STATUS_OK);
      res.frame_type   = (status == lfc_pkg::STATUS_OK) ? rec_type : 8'h00;
      res.frame_length = (status == lfc_pkg::STATUS_OK) ? total[8:0] : 9'd0;
      res.check_status = status;
      expected_results.push_back(res);

      scan_count   = 0;
      hdr_bad      = 1'b0;
      rec_type     = '0;
      pay_len      = '0;
      crc_acc      = cfg_shadow.crc_seed;
      crc_lo_seen  = '0;
      crc_good     = 1'b0;
      frame_closed = 1'b0;
   endfunction

   function automatic void report_field(input string name, input logic [8:0] want_v,
                                        input logic [8:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
         error_count++;
      end
   endfunction

   // Driver: hold the request until taken, then advance to the next byte or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_frame_state(req_payload);
            bytes_taken++;
         end
         if (!req_valid || req_ready) begin
            if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= byte_queue.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every response taken against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, %s%0b %s%0d %s%0d %s%0d",
                        $time, "actual ok=", rsp_payload.frame_ok,
                        "type=", rsp_payload.frame_type,
                        "len=", rsp_payload.frame_length,
                        "st=", rsp_payload.check_status);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               report_field("frame_ok", 9'(want.frame_ok), 9'(rsp_payload.frame_ok));
               report_field("frame_type", 9'(want.frame_type), 9'(rsp_payload.frame_type));
               report_field("frame_length", want.frame_length, rsp_payload.frame_length);
               report_field("check_status", 9'(want.check_status),
                            9'(rsp_payload.check_status));
               results_checked++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses still pending",
                  $time, cycle_count, expected_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      byte_queue.push_back('{data_byte: b, last_byte: last});
      total_queued++;
   endtask

   // Build one buffer: a frame from the current registers, damaged as asked or replaced by noise,
   // followed (unless cut short) by tail_len bytes that the parser must ignore.
   task automatic queue_buffer(input buffer_kind_type kind, input int unsigned plen,
                               input int unsigned tail_len);
      logic [7:0]  frame_bytes[$];
      logic [15:0] crc;
      int unsigned pick;
      int unsigned keep;
      frame_bytes.push_back(cfg_shadow.magic_first);
      frame_bytes.push_back(cfg_shadow.magic_second);
      frame_bytes.push_back(cfg_shadow.format_version);
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(plen[7:0]);
      repeat (plen) frame_bytes.push_back(8'($urandom));
      crc = cfg_shadow.crc_seed;
      for (int k = 2; k < frame_bytes.size(); k++) begin
         crc = crc_ccitt_next(crc, frame_bytes[k]);
      end
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);

      case (kind)
         BUF_BAD_CRC: begin
            // corrupt the type byte or one of the CRC bytes
            pick = $urandom_range(1) ? 3 :
                   $urandom_range(frame_bytes.size() - 1, frame_bytes.size() - 2);
            frame_bytes[pick] = frame_bytes[pick] ^ (8'h01 << $urandom_range(7));
         end
         BUF_BAD_HEADER: begin
            pick = $urandom_range(2);
            frame_bytes[pick] = frame_bytes[pick] ^ (8'h01 << $urandom_range(7));
         end
         BUF_CUT_SHORT: begin
            keep = $urandom_range(frame_bytes.size() - 1, 1);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
         end
         BUF_NOISE: begin
            frame_bytes.delete();
            repeat ($urandom_range(12, 1)) frame_bytes.push_back(8'($urandom));
         end
         default: begin
         end
      endcase
      if (kind != BUF_CUT_SHORT) begin
         repeat (tail_len) frame_bytes.push_back(8'($urandom));
      end
      foreach (frame_bytes[k]) push_byte(frame_bytes[k], k == frame_bytes.size() - 1);
      buffers_queued++;
   endtask

   // Mostly well-formed frames with short payloads, plus damaged ones and noise.
   task automatic queue_random_buffer();
      int unsigned room;
      int unsigned roll;
      int unsigned plen;
      int unsigned tail_len;
      int unsigned over_hi;
      room = cfg_shadow.max_frame_length - lfc_pkg::MIN_FRAME;
      roll = $urandom_range(99);
      plen = ($urandom_range(9) == 0) ? $urandom_range(room) :
                                        $urandom_range((room < 12) ? room : 12);
      tail_len = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
      if (roll < 55) begin
         queue_buffer(BUF_GOOD, plen, tail_len);
      end else if (roll < 67) begin
         queue_buffer(BUF_BAD_CRC, plen, tail_len);
      end else if (roll < 77) begin
         queue_buffer(BUF_BAD_HEADER, plen, tail_len);
      end else if (roll < 87) begin
         queue_buffer(BUF_CUT_SHORT, plen, 0);
      end else if (roll < 95 && room < 255) begin
         // just over the limit, so the length check is exercised near its edge
         over_hi = (room + 11 > 255) ? 255 : room + 11;
         queue_buffer(BUF_OVERSIZE, $urandom_range(over_hi, room + 1), tail_len);
      end else begin
         queue_buffer(BUF_NOISE, 0, 0);
      end
   endtask

   // Drive one CSR write; leave valid high so back-to-back writes need no gap.
   task automatic write_csr(input logic [lfc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         lfc_pkg::CSR_MAGIC_FIRST:      cfg_shadow.magic_first      = val[7:0];
         lfc_pkg::CSR_MAGIC_SECOND:     cfg_shadow.magic_second     = val[7:0];
         lfc_pkg::CSR_FORMAT_VERSION:   cfg_shadow.format_version   = val[7:0];
         lfc_pkg::CSR_MAX_FRAME_LENGTH: cfg_shadow.max_frame_length = val[8:0];
         lfc_pkg::CSR_CRC_SEED:         cfg_shadow.crc_seed         = val;
         default: begin
         end
      endcase
   endtask

   // Write every register, with junk in the unused upper bits, plus one
   // write to an undecoded index that must be dropped.
   task automatic program_config(input logic [7:0] m1, input logic [7:0] m2,
                                 input logic [7:0] ver, input logic [8:0] max_len,
                                 input logic [15:0] seed);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_csr(lfc_pkg::CSR_MAGIC_FIRST, {junk[15:8], m1});
      write_csr(lfc_pkg::CSR_MAGIC_SECOND, {junk[7:0], m2});
      write_csr(lfc_pkg::CSR_FORMAT_VERSION, {junk[11:4], ver});
      write_csr(lfc_pkg::CSR_MAX_FRAME_LENGTH, {junk[14:8], max_len});
      write_csr(lfc_pkg::CSR_CRC_SEED, seed);
      write_csr(CSR_FIRST_UNUSED + 3'($urandom_range(2)), 16'($urandom));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Wait until every request is taken and every response is back, then let
   // the pipeline settle before touching the registers.
   task automatic wait_drained();
      while (bytes_taken != total_queued || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                            input int unsigned min_bytes);
      int unsigned start_bytes;
      int unsigned start_bufs;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      start_bytes   = total_queued;
      start_bufs    = buffers_queued;
      while (total_queued - start_bytes < min_bytes || buffers_queued - start_bufs < 6) begin
         queue_random_buffer();
      end
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at reset values: one-byte buffer, minimal good frame,
      // bad CRC, bad header.
      push_byte(8'hFF, 1'b1);
      buffers_queued++;
      queue_buffer(BUF_GOOD, 0, 0);
      queue_buffer(BUF_BAD_CRC, 0, 0);
      queue_buffer(BUF_BAD_HEADER, 1, 0);
      wait_drained();

      // Largest limit: full 255-byte payload, with two trailing bytes so the
      // byte count saturates. No idling.
      program_config(8'hA5, 8'h5A, 8'h01, 9'd262, 16'hFFFF);
      queue_buffer(BUF_GOOD, 255, 2);
      wait_drained();

      // Smallest limit, zero seed; sender mostly idle.
      program_config(8'h00, 8'hFF, 8'hFF, lfc_pkg::MIN_FRAME, 16'h0000);
      run_phase(75, 0, 36);

      // Random header and seed, moderate limit; receiver mostly stalled.
      program_config(8'($urandom), 8'($urandom), 8'($urandom),
                     9'($urandom_range(100, 8)), 16'($urandom));
      run_phase(0, 75, 36);

      // Light idling on both sides.
      program_config(8'hFF, 8'h00, 8'h00, 9'($urandom_range(262, 7)), 16'($urandom));
      run_phase(12, 12, 36);

      program_config(8'($urandom), 8'($urandom), 8'($urandom),
                     9'($urandom_range(262, 7)), 16'($urandom));
      run_phase(0, 0, 36);

      repeat (8) @(posedge clock);
      $display("Sent %0d buffers (%0d bytes) under %0d register settings plus reset values,",
               buffers_queued, bytes_taken, settings_applied);
      $display("compared %0d responses field by field.", results_checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
